[hw/rtl/move_to_front_coder_assert.svh]
// Assertion macros for the move-to-front coder RTL.
// Included by modules that check their own logic; no other dependencies.
`ifndef MOVE_TO_FRONT_CODER_ASSERT_SVH
`define MOVE_TO_FRONT_CODER_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is low.
`define MTF_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, disabled while reset is low.
`define MTF_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define MTF_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg)
`define MTF_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

[hw/rtl/mtf_pkg.sv]
// Shared types and constants for the move-to-front coder.
// No dependencies; imported by all modules of the block.
`timescale 1ns / 1ps
`default_nettype none

package mtf_pkg;

    localparam int BYTE_W            = 8;
    localparam int ALPHABET_SIZE_DEF = 256;

    // Input word
    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              block_end;
    } in_word_t;

    // Result word
    typedef struct packed {
        logic [BYTE_W-1:0] coded_byte;
        logic              block_end_out;
    } out_word_t;

    // Controller to datapath commands
    typedef struct packed {
        logic start;   // latch input word, issue read of position 0
        logic scan;    // process one list entry, issue read of the next
        logic finish;  // write front entry after a hit, load result register
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic in_range;  // incoming byte lies inside the alphabet
        logic hit;       // current list entry ends the sweep
        logic out_free;  // result register can take a word this cycle
    } status_t;

endpackage

`default_nettype wire

[hw/rtl/mtf_ctrl.sv]
// Sequencer for the move-to-front coder: accept, sweep the list, deliver.
// Depends on mtf_pkg for the command and status structs.
`timescale 1ns / 1ps
`default_nettype none

module mtf_ctrl (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_valid,
    output logic                 s_ready,
    input  mtf_pkg::status_t     status,
    output mtf_pkg::cmd_t        cmd
);
    import mtf_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

    state_t state_reg;
    logic   s_ready_reg;

    // Decode commands from state and handshake
    always_comb begin
        cmd.start  = s_valid && s_ready_reg;
        cmd.scan   = (state_reg == ST_SCAN);
        cmd.finish = (state_reg == ST_FINISH) && status.out_free;
    end

    assign s_ready = s_ready_reg;

    // Hold state and the registered ready
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            s_ready_reg <= 1'b1;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid && s_ready_reg) begin
                        s_ready_reg <= 1'b0;
                        state_reg   <= status.in_range ? ST_SCAN : ST_FINISH;
                    end
                end
                ST_SCAN: begin
                    if (status.hit) begin
                        state_reg <= ST_FINISH;
                    end
                end
                ST_FINISH: begin
                    if (status.out_free) begin
                        state_reg   <= ST_IDLE;
                        s_ready_reg <= 1'b1;
                    end
                end
                default: begin
                    state_reg   <= ST_IDLE;
                    s_ready_reg <= 1'b1;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

[hw/rtl/mtf_datapath.sv]
// Datapath of the move-to-front coder: list memory, sweep registers, result register.
// Depends on mtf_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none

`include "move_to_front_coder_assert.svh"

module mtf_datapath #(
    parameter int ALPHABET_SIZE = mtf_pkg::ALPHABET_SIZE_DEF
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_we,
    input  wire logic               cfg_wdata,
    input  mtf_pkg::in_word_t       s_data,
    input  wire logic               m_ready,
    output logic                    m_valid,
    output mtf_pkg::out_word_t      m_data,
    input  mtf_pkg::cmd_t           cmd,
    output mtf_pkg::status_t        status
);
    import mtf_pkg::*;

    localparam int                AW       = $clog2(ALPHABET_SIZE);
    localparam logic [AW-1:0]     LAST_POS = AW'(ALPHABET_SIZE - 1);
    localparam logic [BYTE_W:0]   SIZE_EXT = (BYTE_W + 1)'(ALPHABET_SIZE);

    // Configuration and current word
    logic              direction_reg;
    logic [BYTE_W-1:0] data_reg;
    logic              last_reg;

    // List memory; a cleared valid bit means the entry holds its own position
    logic [AW-1:0]            list_mem [ALPHABET_SIZE];
    logic [ALPHABET_SIZE-1:0] valid_reg;

    // Registered read port
    logic [AW-1:0] rd_data_reg;
    logic          rd_valid_reg;
    logic [AW-1:0] rd_pos_reg;

    // Sweep state and result
    logic [AW-1:0]     prev_reg;
    logic [AW-1:0]     sym_reg;
    logic              front_reg;
    logic [BYTE_W-1:0] result_reg;
    logic              m_valid_reg;
    out_word_t         m_data_reg;

    logic [AW-1:0] raddr;
    logic [AW-1:0] cur_val;
    logic [AW-1:0] key;
    logic          hit;
    logic          wr_en;
    logic [AW-1:0] waddr;
    logic [AW-1:0] wdata;

    // Sweep addressing and match
    always_comb begin
        if (cmd.start || rd_pos_reg == LAST_POS) begin
            raddr = '0;
        end else begin
            raddr = rd_pos_reg + AW'(1);
        end
        cur_val = rd_valid_reg ? rd_data_reg : rd_pos_reg;
        key     = data_reg[AW-1:0];
        hit     = direction_reg ? (rd_pos_reg == key) : (cur_val == key);
    end

    // Shift one entry down per scan step; put the moved symbol at the front on finish
    always_comb begin
        wr_en = (cmd.scan && rd_pos_reg != '0) || (cmd.finish && front_reg);
        waddr = cmd.scan ? rd_pos_reg : '0;
        wdata = cmd.scan ? prev_reg : sym_reg;
    end

    always_comb begin
        status.in_range = {1'b0, s_data.data_byte} < SIZE_EXT;
        status.hit      = hit;
        status.out_free = !m_valid_reg || m_ready;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Control registers: direction, valid bits, result valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            direction_reg <= 1'b0;
            valid_reg     <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (cfg_we) begin
                direction_reg <= cfg_wdata;
            end
            if (cmd.finish && last_reg) begin
                valid_reg <= '0;
            end else if (wr_en) begin
                valid_reg[waddr] <= 1'b1;
            end
            if (cmd.finish) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Memory write and registered read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            list_mem[waddr] <= wdata;
        end
        rd_data_reg  <= list_mem[raddr];
        rd_valid_reg <= valid_reg[raddr];
        rd_pos_reg   <= raddr;
    end

    // Word latch, sweep carry and result
    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            data_reg   <= s_data.data_byte;
            last_reg   <= s_data.block_end;
            result_reg <= s_data.data_byte;
            front_reg  <= 1'b0;
        end
        if (cmd.scan) begin
            prev_reg <= cur_val;
            if (hit) begin
                result_reg <= direction_reg ? BYTE_W'(cur_val) : BYTE_W'(rd_pos_reg);
                sym_reg    <= cur_val;
                front_reg  <= 1'b1;
            end
        end
        if (cmd.finish) begin
            m_data_reg.coded_byte    <= result_reg;
            m_data_reg.block_end_out <= last_reg;
        end
    end

    // Decode sweep never passes the requested position
    `MTF_ASSERT_SAME(a_dec_bound, aclk, aresetn, cmd.scan && direction_reg, rd_pos_reg <= key, "decode sweep ran past target position")
    // Sweep stops at the first hit
    `MTF_ASSERT_SAME(a_scan_no_front, aclk, aresetn, cmd.scan, !front_reg, "scan step after the sweep already hit")
    // Block end leaves the list in identity order
    `MTF_ASSERT_NEXT(a_block_reset, aclk, aresetn, cmd.finish && last_reg, valid_reg == '0, "list not restored after block end")

endmodule

`default_nettype wire

[hw/rtl/move_to_front_coder.sv]
// Flow: a byte outside the alphabet goes from accept straight to the finish state; a byte at
// list position p is found by a sweep from position 0 (one list entry read per cycle).
// The sweep runs over the list memory; a new word is accepted only after the last one finishes;
// the result register lets the next word start while a result waits.
// Reset: direction is encode, list in identity order through cleared valid bits, no clear pass.
`timescale 1ns / 1ps
`default_nettype none

module move_to_front_coder #(
    parameter int ALPHABET_SIZE = mtf_pkg::ALPHABET_SIZE_DEF
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           cfg_we,
    input  wire logic           cfg_wdata,
    input  wire logic           s_valid,
    output logic                s_ready,
    input  mtf_pkg::in_word_t   s_data,
    output logic                m_valid,
    input  wire logic           m_ready,
    output mtf_pkg::out_word_t  m_data
);
    import mtf_pkg::*;

    cmd_t    cmd;
    status_t status;

    // Sequencer
    mtf_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // List memory and result path
    mtf_datapath #(
        .ALPHABET_SIZE (ALPHABET_SIZE)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_data    (s_data),
        .m_ready   (m_ready),
        .m_valid   (m_valid),
        .m_data    (m_data),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

`default_nettype wire
